// ----- sv/u8sv_pkg.sv -----
`default_nettype none

package u8sv_pkg;

   // One input transfer as it travels from the input register to the checker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_item;
   } u8sv_item_type;

   // Checker state seen from the top level.
   typedef struct packed {
      logic seq_open;
      logic error_seen;
   } u8sv_status_type;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] MIN_TWO     = 8'hC2;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] MIN_E0_CONT = 8'hA0;
   localparam logic [7:0] LEAD_ED     = 8'hED;
   localparam logic [7:0] MAX_ED_CONT = 8'h9F;
   localparam logic [7:0] LEAD_EF     = 8'hEF;
   localparam logic [7:0] CONT_BF     = 8'hBF;
   localparam logic [7:0] CONT_BE     = 8'hBE;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] MIN_F0_CONT = 8'h90;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] MAX_F4_CONT = 8'h8F;

   localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

`default_nettype wire

// ----- sv/utf8_stream_validator_unit.sv -----
// UTF-8 stream validator.
// Input channel (req_): one item per transfer, a byte with has_byte = 1, and
// last_item = 1 on the final item of a string. An item with has_byte = 0 and
// last_item = 1 closes a string without adding a byte (empty string is valid).
// Result channel (rsp_): one transfer per string, rsp_string_valid = 1 when
// the whole string was well-formed UTF-8, sent after the item marked last.
// Both channels: a transfer happens on a clock edge with valid high and
// stall low.
// Path: the last item passes from the input register to the result register,
// and the verdict is on rsp_ once it is in the result register. Throughput: one
// item per cycle while req_stall is low, with no bubbles between strings; the
// single-pass check between the two registers sets this.
// Reset (synchronous, active high) empties both registers and clears the
// checker so the next item starts a new string.
// When the receiver stalls, the verdict waits in the result register; items
// that are not last keep flowing, and req_stall rises only when a last item
// is held behind an unclaimed verdict.
`default_nettype none

module utf8_stream_validator_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_has_byte,
   input  wire logic       req_last_item,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_string_valid
);

   logic                    in_valid_ff, in_valid_in;
   u8sv_pkg::u8sv_item_type in_item_ff, in_item_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_data_ff, out_data_in;
   logic                    advance;
   logic                    req_take;
   logic                    verdict;
   u8sv_pkg::u8sv_status_type status;

   // Non-last items never need the result register.
   assign advance  = in_valid_ff &&
                     (!in_item_ff.last_item || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   u8sv_check u_check (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_item_ff),
      .verdict (verdict),
      .status  (status)
   );

   always_comb begin
      in_valid_in          = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in           = in_item_ff;
      if (req_take) begin
         in_item_in.data_byte = req_data_byte;
         in_item_in.has_byte  = req_has_byte;
         in_item_in.last_item = req_last_item;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (advance && in_item_ff.last_item) begin
         out_valid_in = 1'b1;
         out_data_in  = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_string_valid = out_data_ff;

   a_stall_only_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_item_ff.last_item && out_valid_ff))
      else $error("input stalled without a pending verdict");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) && !(advance && in_item_ff.last_item) |=> !rsp_valid)
      else $error("verdict appeared without a last item");

   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.last_item) |=> (!status.seq_open && !status.error_seen))
      else $error("checker state not cleared after verdict");

endmodule

`default_nettype wire

// ----- sv/u8sv_check.sv -----
`default_nettype none

module u8sv_check (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire u8sv_pkg::u8sv_item_type   item,
   output logic                           verdict,
   output u8sv_pkg::u8sv_status_type      status
);

   logic [1:0] bytes_left_ff,    bytes_left_in;
   logic [7:0] lead_byte_ff,     lead_byte_in;
   logic [1:0] cont_position_ff, cont_position_in;
   logic       ef_bf_seen_ff,    ef_bf_seen_in;
   logic       error_seen_ff,    error_seen_in;

   logic [1:0] left_nx;
   logic [7:0] lead_nx;
   logic [1:0] pos_nx;
   logic       efbf_nx;
   logic       err_nx;
   logic [7:0] b;

   always_comb begin
      b       = item.data_byte;
      left_nx = bytes_left_ff;
      lead_nx = lead_byte_ff;
      pos_nx  = cont_position_ff;
      efbf_nx = ef_bf_seen_ff;
      err_nx  = error_seen_ff;

      if (item.has_byte && !error_seen_ff) begin
         if (bytes_left_ff == 2'd0) begin
            lead_nx = b;
            pos_nx  = 2'd1;
            efbf_nx = 1'b0;
            left_nx = 2'd0;
            if (b < u8sv_pkg::ASCII_LIMIT) begin
               left_nx = 2'd0;
            end else if (b[7:5] == 3'b110) begin
               left_nx = 2'd1;
               if (b < u8sv_pkg::MIN_TWO) err_nx = 1'b1;
            end else if (b[7:4] == 4'b1110) begin
               left_nx = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               left_nx = 2'd3;
               if (b > u8sv_pkg::LEAD_F4) err_nx = 1'b1;
            end else begin
               err_nx = 1'b1;
            end
         end else if (b[7:6] != u8sv_pkg::CONT_TAG) begin
            err_nx = 1'b1;
         end else begin
            case (cont_position_ff)
               2'd1: begin
                  if (lead_byte_ff == u8sv_pkg::LEAD_E0 && b < u8sv_pkg::MIN_E0_CONT)
                     err_nx = 1'b1;
                  if (lead_byte_ff == u8sv_pkg::LEAD_ED && b > u8sv_pkg::MAX_ED_CONT)
                     err_nx = 1'b1;
                  if (lead_byte_ff == u8sv_pkg::LEAD_F0 && b < u8sv_pkg::MIN_F0_CONT)
                     err_nx = 1'b1;
                  if (lead_byte_ff == u8sv_pkg::LEAD_F4 && b > u8sv_pkg::MAX_F4_CONT)
                     err_nx = 1'b1;
                  efbf_nx = (lead_byte_ff == u8sv_pkg::LEAD_EF) && (b == u8sv_pkg::CONT_BF);
               end
               2'd2: begin
                  // noncharacters U+FFFE / U+FFFF
                  if (lead_byte_ff == u8sv_pkg::LEAD_EF && ef_bf_seen_ff &&
                      (b == u8sv_pkg::CONT_BE || b == u8sv_pkg::CONT_BF))
                     err_nx = 1'b1;
               end
               default: begin
               end
            endcase
            pos_nx  = cont_position_ff + 2'd1;
            left_nx = bytes_left_ff - 2'd1;
         end
      end

      verdict = !err_nx && (left_nx == 2'd0);

      if (item.last_item) begin
         bytes_left_in    = 2'd0;
         lead_byte_in     = 8'd0;
         cont_position_in = 2'd0;
         ef_bf_seen_in    = 1'b0;
         error_seen_in    = 1'b0;
      end else begin
         bytes_left_in    = left_nx;
         lead_byte_in     = lead_nx;
         cont_position_in = pos_nx;
         ef_bf_seen_in    = efbf_nx;
         error_seen_in    = err_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff    <= 2'd0;
         lead_byte_ff     <= 8'd0;
         cont_position_ff <= 2'd0;
         ef_bf_seen_ff    <= 1'b0;
         error_seen_ff    <= 1'b0;
      end else if (step) begin
         bytes_left_ff    <= bytes_left_in;
         lead_byte_ff     <= lead_byte_in;
         cont_position_ff <= cont_position_in;
         ef_bf_seen_ff    <= ef_bf_seen_in;
         error_seen_ff    <= error_seen_in;
      end
   end

   assign status.seq_open   = (bytes_left_ff != 2'd0);
   assign status.error_seen = error_seen_ff;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned BYTE_TARGET  = 1800;
   localparam int unsigned DRAIN_CYCLES = 8;

   // Directed row: one input item plus an optional hand-typed verdict.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_item;
      logic       typed;
      logic       verdict;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_has_byte = 1'b0;
   logic       req_last_item = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_string_valid;

   // Predictor state: one open UTF-8 sequence and a sticky error.
   logic [1:0] cont_left = 2'd0;
   logic [7:0] lead_seen = 8'h00;
   logic [1:0] cont_pos = 2'd0;
   logic       bf_prefix = 1'b0;
   logic       err_seen = 1'b0;

   logic                      verdict_q[$];
   u8sv_pkg::u8sv_item_type   string_q[$];
   logic                      exp_verdict;
   int unsigned               fail_count = 0;
   int unsigned               cycle_count = 0;
   int unsigned               bytes_sent = 0;
   int unsigned               stall_run = 0;
   logic                      calm = 1'b0;

   dir_row_type directed_rows [24] = '{
      // empty string
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
      // ASCII extremes with an ignored item in between
      '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h7F, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h41, 1'b1, 1'b1, 1'b0, 1'b0},
      // smallest legal two-byte form
      '{8'hC2, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
      // overlong two-byte lead
      '{8'hC0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
      // overlong three-byte form
      '{8'hE0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h9F, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
      // surrogate
      '{8'hED, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hA0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
      // noncharacter U+FFFE
      '{8'hEF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hBE, 1'b1, 1'b1, 1'b1, 1'b0},
      // U+10FFFF, the top code point
      '{8'hF4, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h8F, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, 1'b1, 1'b0, 1'b0},
      // illegal lead, then a sequence left open at the end
      '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
      '{8'hE2, 1'b1, 1'b1, 1'b1, 1'b0}
   };

   utf8_stream_validator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_string_valid (rsp_string_valid)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stretches with no idling on either side.
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0)
         calm = ~calm;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_run != 0) begin
         stall_run = stall_run - 1;
      end else if (rsp_stall || calm) begin
         rsp_stall <= 1'b0;
         stall_run = $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b1;
         stall_run = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            fail_count++;
            $display("%0t: verdict with none expected, actual %0b",
                     $time, rsp_string_valid);
         end else begin
            exp_verdict = verdict_q.pop_front();
            if (exp_verdict !== rsp_string_valid) begin
               fail_count++;
               $display("%0t: string_valid mismatch, expected %0b actual %0b",
                        $time, exp_verdict, rsp_string_valid);
            end
         end
      end
   end

   // Advances the checker by one item; the return value is the verdict the
   // string would get if it ended here.
   function automatic logic utf8_advance(input u8sv_pkg::u8sv_item_type it);
      logic [7:0] b;
      logic       verdict;
      b = it.data_byte;
      if (it.has_byte && !err_seen) begin
         if (cont_left == 2'd0) begin
            lead_seen = b;
            cont_pos  = 2'd1;
            bf_prefix = 1'b0;
            if (b < u8sv_pkg::ASCII_LIMIT) begin
               cont_left = 2'd0;
            end else if (b[7:5] == 3'b110) begin
               cont_left = 2'd1;
               if (b < u8sv_pkg::MIN_TWO)
                  err_seen = 1'b1;
            end else if (b[7:4] == 4'hE) begin
               cont_left = 2'd2;
            end else if (b[7:3] == 5'h1E) begin
               cont_left = 2'd3;
               if (b > u8sv_pkg::LEAD_F4)
                  err_seen = 1'b1;
            end else begin
               cont_left = 2'd0;
               err_seen  = 1'b1;
            end
         end else if (b[7:6] != u8sv_pkg::CONT_TAG) begin
            err_seen = 1'b1;
         end else begin
            if (cont_pos == 2'd1) begin
               if ((lead_seen == u8sv_pkg::LEAD_E0 && b < u8sv_pkg::MIN_E0_CONT) ||
                   (lead_seen == u8sv_pkg::LEAD_ED && b > u8sv_pkg::MAX_ED_CONT) ||
                   (lead_seen == u8sv_pkg::LEAD_F0 && b < u8sv_pkg::MIN_F0_CONT) ||
                   (lead_seen == u8sv_pkg::LEAD_F4 && b > u8sv_pkg::MAX_F4_CONT))
                  err_seen = 1'b1;
               bf_prefix = (lead_seen == u8sv_pkg::LEAD_EF && b == u8sv_pkg::CONT_BF);
            end else if (cont_pos == 2'd2 && lead_seen == u8sv_pkg::LEAD_EF && bf_prefix &&
                         (b == u8sv_pkg::CONT_BE || b == u8sv_pkg::CONT_BF)) begin
               err_seen = 1'b1;
            end
            cont_pos  = cont_pos + 2'd1;
            cont_left = cont_left - 2'd1;
         end
      end
      verdict = !err_seen && cont_left == 2'd0;
      if (it.last_item) begin
         cont_left = 2'd0;
         lead_seen = 8'h00;
         cont_pos  = 2'd0;
         bf_prefix = 1'b0;
         err_seen  = 1'b0;
      end
      return verdict;
   endfunction

   // One transfer on the request channel, with a random lead-in gap. The
   // verdict is queued at the accepting edge.
   task automatic send_item(input u8sv_pkg::u8sv_item_type it, input logic typed,
                            input logic typed_verdict);
      int unsigned gap;
      logic        predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= it.data_byte;
      req_has_byte  <= it.has_byte;
      req_last_item <= it.last_item;
      do @(posedge clock); while (req_stall);
      predicted = utf8_advance(it);
      if (it.has_byte)
         bytes_sent++;
      if (it.last_item)
         verdict_q.push_back(typed ? typed_verdict : predicted);
   endtask

   function automatic void push_byte(input logic [7:0] b);
      string_q.push_back('{b, 1'b1, 1'b0});
   endfunction

   function automatic void push_code_point(input int unsigned cp);
      if (cp < 32'h80) begin
         push_byte(cp[7:0]);
      end else if (cp < 32'h800) begin
         push_byte({3'b110, cp[10:6]});
         push_byte({u8sv_pkg::CONT_TAG, cp[5:0]});
      end else if (cp < 32'h10000) begin
         push_byte({4'hE, cp[15:12]});
         push_byte({u8sv_pkg::CONT_TAG, cp[11:6]});
         push_byte({u8sv_pkg::CONT_TAG, cp[5:0]});
      end else begin
         push_byte({5'h1E, cp[20:18]});
         push_byte({u8sv_pkg::CONT_TAG, cp[17:12]});
         push_byte({u8sv_pkg::CONT_TAG, cp[11:6]});
         push_byte({u8sv_pkg::CONT_TAG, cp[5:0]});
      end
   endfunction

   // Mostly well-formed characters; a few land on range edges, including the
   // illegal ones just past them.
   function automatic void push_char();
      int unsigned cp;
      case ($urandom_range(0, 9))
         0, 1, 2: cp = $urandom_range(0, 32'h7F);
         3:       cp = $urandom_range(32'h80, 32'h7FF);
         4:       cp = $urandom_range(32'h800, 32'hFFFF);
         5:       cp = $urandom_range(32'h10000, 32'h10FFFF);
         6:       cp = 32'hFFC0 + $urandom_range(0, 63);
         7: begin
            case ($urandom_range(0, 11))
               0:  cp = 32'h7FF;
               1:  cp = 32'h800;
               2:  cp = 32'hD7FF;
               3:  cp = 32'hD800;
               4:  cp = 32'hDFFF;
               5:  cp = 32'hE000;
               6:  cp = 32'hFFFD;
               7:  cp = 32'h10000;
               8:  cp = 32'h10FFFF;
               9:  cp = 32'h110000;
               10: cp = 32'h1FFFFF;
               default: cp = 32'hFFFF;
            endcase
         end
         default: cp = $urandom_range(32'h80, 32'h10FFFF);
      endcase
      push_code_point(cp);
   endfunction

   function automatic void corrupt_string();
      u8sv_pkg::u8sv_item_type junk;
      junk = '{8'($urandom_range(0, 255)), 1'b1, 1'b0};
      case ($urandom_range(0, 4))
         0: string_q.insert($urandom_range(0, string_q.size()), junk);
         1: if (string_q.size() != 0) void'(string_q.pop_back());
         2: begin
            // two-byte overlong
            push_byte(8'hC0 | 8'($urandom_range(0, 1)));
            push_byte(8'h80 | 8'($urandom_range(0, 63)));
         end
         3: begin
            // second byte just outside the legal window of a special lead
            case ($urandom_range(0, 3))
               0: begin
                  push_byte(u8sv_pkg::LEAD_E0);
                  push_byte(8'($urandom_range(8'h80, 8'h9F)));
               end
               1: begin
                  push_byte(u8sv_pkg::LEAD_ED);
                  push_byte(8'($urandom_range(8'hA0, 8'hBF)));
               end
               2: begin
                  push_byte(u8sv_pkg::LEAD_F0);
                  push_byte(8'($urandom_range(8'h80, 8'h8F)));
               end
               default: begin
                  push_byte(u8sv_pkg::LEAD_F4);
                  push_byte(8'($urandom_range(8'h90, 8'hBF)));
               end
            endcase
            push_byte(8'h80 | 8'($urandom_range(0, 63)));
         end
         default: begin
            // lead byte followed by something that is not a continuation
            push_byte(8'hE0 | 8'($urandom_range(0, 15)));
            push_byte(8'($urandom_range(0, 8'h7F)) | 8'(($urandom_range(0, 1)) << 6));
         end
      endcase
   endfunction

   initial begin
      u8sv_pkg::u8sv_item_type closer;
      int unsigned             n_chars;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item('{directed_rows[i].data_byte, directed_rows[i].has_byte,
                     directed_rows[i].last_item},
                   directed_rows[i].typed, directed_rows[i].verdict);

      while (bytes_sent < BYTE_TARGET) begin
         string_q.delete();
         n_chars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         repeat (n_chars) push_char();
         if ($urandom_range(0, 3) == 0)
            corrupt_string();
         closer = '{8'($urandom_range(0, 255)), 1'b0, 1'b1};
         if (string_q.size() != 0 && $urandom_range(0, 2) != 0)
            string_q[string_q.size() - 1].last_item = 1'b1;
         else
            string_q.push_back(closer);
         foreach (string_q[i]) begin
            // an occasional item without a byte that the block must skip
            if ($urandom_range(0, 19) == 0)
               send_item('{8'($urandom_range(0, 255)), 1'b0, 1'b0}, 1'b0, 1'b0);
            send_item(string_q[i], 1'b0, 1'b0);
         end
      end
      req_valid <= 1'b0;

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/u8sv_pkg.sv
sv/u8sv_check.sv
sv/utf8_stream_validator_unit.sv
sim/tb.sv
